// ===== sv/rdd_pkg.sv =====
// Shared types and codes for the ring deque with delete.
// No dependencies; imported by rdd_out_reg and ring_deque_with_delete_core.
package rdd_pkg;

  // Action codes carried on the input tuser
  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_TAKE   = 2'd2,
    ACT_DELETE = 2'd3
  } action_e;

  // Result status codes carried on the output tuser
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_DEL  = 2'd2,
    S_FIN  = 2'd3
  } state_e;

  localparam int VALUE_W = 32;
  localparam int FILL_W  = 5;

  // One result as it travels to the output register
  typedef struct packed {
    status_e              status;
    logic [VALUE_W-1:0]   value;
    logic [FILL_W-1:0]    fill;
  } result_t;

endpackage

// ===== sv/rdd_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rdd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rdd_out_reg.sv =====
// Output register of the ring deque: holds one result until the sink takes it.
// Depends on rdd_pkg for the result type.
module rdd_out_reg
  import rdd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    free_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // slot can take a new result when empty or drained this cycle
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== sv/ring_deque_with_delete_core.sv =====
// Ring deque with delete: push, pop newest, take oldest, delete by key.
// Push, failed actions and empty delete load the output register at the transfer, valid
// in the cycle after; pop and take pass the RAM read register and S_READ, delete S_DEL and
// S_FIN, then the output register. Push: one per cycle while the output is free; pop and
// take stall input in S_READ; delete walks stored items through the RAM read port, one a cycle.
// Reset clears count and pointers; RAM contents are undefined until written.
module ring_deque_with_delete_core
  import rdd_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] item_value
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] read_value, [36:32] fill_count, rest zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  function automatic logic [PTR_W-1:0] step_up(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
  endfunction

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [PTR_W-1:0]       newest_q, newest_d;
  logic [PTR_W-1:0]       oldest_q, oldest_d;
  logic [CNT_W-1:0]       rem_q, rem_d;
  logic [CNT_W-1:0]       kept_q, kept_d;
  logic [CNT_W-1:0]       before_q, before_d;
  logic                   pend_q, pend_d;
  logic [ITEM_WIDTH-1:0]  key_q, key_d;

  logic                   ram_we, ram_re;
  logic [PTR_W-1:0]       ram_waddr, ram_raddr;
  logic [ITEM_WIDTH-1:0]  ram_wdata, ram_rdata;

  logic                   out_free, out_load;
  result_t                out_res, out_q;

  logic                   accept;
  logic                   issue;
  logic [ITEM_WIDTH-1:0]  item_w;
  action_e                act;

  assign item_w        = ITEM_WIDTH'(s_axis_tdata);
  assign act           = action_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // controller: next state, pointer updates, RAM accesses, result load
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    newest_d   = newest_q;
    oldest_d   = oldest_q;
    rem_d      = rem_q;
    kept_d     = kept_q;
    before_d   = before_q;
    pend_d     = 1'b0;
    key_d      = key_q;
    ram_we     = 1'b0;
    ram_waddr  = newest_q;
    ram_wdata  = item_w;
    ram_re     = 1'b0;
    ram_raddr  = oldest_q;
    out_load   = 1'b0;
    out_res.status = STAT_OK;
    out_res.value  = '0;
    issue      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (act)
            ACT_PUSH: begin
              out_load = 1'b1;
              if (cnt_q == CNT_W'(DEPTH)) begin
                out_res.status = STAT_FULL;
              end else begin
                ram_we   = 1'b1;
                newest_d = step_up(newest_q);
                cnt_d    = cnt_q + 1'b1;
              end
            end
            ACT_POP: begin
              if (cnt_q == '0) begin
                out_load       = 1'b1;
                out_res.status = STAT_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = step_down(newest_q);
                newest_d  = step_down(newest_q);
                cnt_d     = cnt_q - 1'b1;
                state_d   = S_READ;
              end
            end
            ACT_TAKE: begin
              if (cnt_q == '0) begin
                out_load       = 1'b1;
                out_res.status = STAT_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = oldest_q;
                oldest_d  = step_up(oldest_q);
                cnt_d     = cnt_q - 1'b1;
                state_d   = S_READ;
              end
            end
            ACT_DELETE: begin
              if (cnt_q == '0) begin
                out_load       = 1'b1;
                out_res.status = STAT_NOT_FOUND;
              end else begin
                key_d    = item_w;
                rem_d    = cnt_q;
                before_d = cnt_q;
                kept_d   = '0;
                state_d  = S_DEL;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end

      // read data of pop or take is on the RAM output now
      S_READ: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_res.value = VALUE_W'(ram_rdata);
          state_d       = S_IDLE;
        end
      end

      // walk: read oldest, compare in the following cycle, write survivors at newest
      S_DEL: begin
        issue = (rem_q != '0);
        if (issue) begin
          ram_re    = 1'b1;
          ram_raddr = oldest_q;
          oldest_d  = step_up(oldest_q);
          rem_d     = rem_q - 1'b1;
        end
        pend_d = issue;
        if (pend_q && (ram_rdata != key_q)) begin
          ram_we    = 1'b1;
          ram_waddr = newest_q;
          ram_wdata = ram_rdata;
          newest_d  = step_up(newest_q);
          kept_d    = kept_q + 1'b1;
        end
        if (!issue && pend_q) begin
          cnt_d   = kept_d;
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_res.status = (cnt_q < before_q) ? STAT_OK : STAT_NOT_FOUND;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_res.fill = FILL_W'(cnt_d);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      newest_q <= '0;
      oldest_q <= '0;
      rem_q    <= '0;
      kept_q   <= '0;
      pend_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      newest_q <= newest_d;
      oldest_q <= oldest_d;
      rem_q    <= rem_d;
      kept_q   <= kept_d;
      pend_q   <= pend_d;
    end
  end

  // delete operands
  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    before_q <= before_d;
  end

  rdd_ram #(
    .WIDTH (ITEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rdd_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (out_load),
    .res_i   (out_res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_q)
  );

  assign m_axis_tdata = {3'b000, out_q.fill, out_q.value};
  assign m_axis_tuser = out_q.status;

endmodule
